### rtl/core/ioc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_pkg: shared types and constants for the index of coincidence engine
// Item structs, the sequencer state type, bank control and fixed constants.
// ----------------------------------------------------------------------------
package ioc_pkg;

	// Default bound on the message length.
	localparam int unsigned IOC_MAX_LENGTH = 32'd65535;

	// Letter range and counter bank geometry.
	localparam int          IOC_LETTERS     = 26;
	localparam int          IOC_IDX_W       = 5;
	localparam logic [7:0]  IOC_CHAR_A      = 8'd65;
	localparam logic [7:0]  IOC_CHAR_Z      = 8'd90;
	localparam logic [IOC_IDX_W-1:0] IOC_LAST_IDX = IOC_IDX_W'(IOC_LETTERS - 1);

	// Fixed point: 16 fraction bits, so 1.0 is 65536.
	localparam int          IOC_FRAC_BITS   = 16;
	localparam int          IOC_ITER_W      = 4;
	localparam logic [16:0] IOC_ONE         = 17'h10000;

	// Input item.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_byte;
	} ioc_in_t;

	// Result item.
	typedef struct packed {
		logic [31:0] pair_sum;
		logic [15:0] total_length;
		logic [16:0] ioc_fixed;
		logic        degenerate_flag;
		logic        overflow_flag;
	} ioc_out_t;

	// Control from the sequencer to the counter bank.
	typedef struct packed {
		logic                 clear;
		logic [IOC_IDX_W-1:0] rd_idx;
	} ioc_bank_ctl_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DENOM,
		ST_DENREG,
		ST_DIV,
		ST_DONE
	} ioc_state_t;

endpackage

### rtl/core/ioc_count_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_count_bank: letter counters and message length counter
// Counts accepted bytes and letters A to Z, flags bytes dropped at the bound.
// ----------------------------------------------------------------------------
module ioc_count_bank
	import ioc_pkg::*;
#(
	parameter int unsigned MAX_LENGTH = IOC_MAX_LENGTH,
	parameter int          CNT_W      = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           char_byte,
	input  ioc_bank_ctl_t        bank_ctl,
	output logic [CNT_W-1:0]     rd_count,
	output logic [CNT_W-1:0]     byte_count,
	output logic                 overflow_seen
);

	logic [CNT_W-1:0]     cnt_q [IOC_LETTERS];
	logic [CNT_W-1:0]     len_q;
	logic                 ovf_q;
	logic                 at_bound;
	logic                 is_letter;
	logic [7:0]           letter_off;
	logic [IOC_IDX_W-1:0] letter_idx;
	logic                 count_en;

	// Decode the byte and check the length bound.
	always_comb begin
		at_bound   = (len_q == CNT_W'(MAX_LENGTH));
		is_letter  = (char_byte >= IOC_CHAR_A) && (char_byte <= IOC_CHAR_Z);
		letter_off = char_byte - IOC_CHAR_A;
		letter_idx = letter_off[IOC_IDX_W-1:0];
		count_en   = byte_en && !at_bound;
	end

	// Length counter and dropped-byte flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (bank_ctl.clear) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (byte_en) begin
			if (at_bound) begin
				ovf_q <= 1'b1;
			end else begin
				len_q <= len_q + 1'b1;
			end
		end
	end

	// One counter per letter, each with its own increment.
	for (genvar g = 0; g < IOC_LETTERS; g++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[g] <= '0;
			end else if (bank_ctl.clear) begin
				cnt_q[g] <= '0;
			end else if (count_en && is_letter && (letter_idx == IOC_IDX_W'(g))) begin
				cnt_q[g] <= cnt_q[g] + 1'b1;
			end
		end
	end

	// Read port used by the sequencer walk.
	always_comb begin
		if (bank_ctl.rd_idx <= IOC_LAST_IDX) begin
			rd_count = cnt_q[bank_ctl.rd_idx];
		end else begin
			rd_count = '0;
		end
	end

	assign byte_count    = len_q;
	assign overflow_seen = ovf_q;

endmodule

### rtl/core/ioc_ratio_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_ratio_unit: sequencer with shared multiplier and restoring divider
// Walks the letter counters, forms the pair sum and denominator, divides.
// ----------------------------------------------------------------------------
module ioc_ratio_unit
	import ioc_pkg::*;
#(
	parameter int CNT_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             launch,
	input  logic [CNT_W-1:0] rd_count,
	input  logic [CNT_W-1:0] byte_count,
	input  logic             overflow_seen,
	output ioc_bank_ctl_t    bank_ctl,
	output logic             busy,
	output logic             done,
	output ioc_out_t         result
);

	localparam int PROD_W = 2 * CNT_W;

	ioc_state_t            state_q, state_nx;
	logic [IOC_IDX_W-1:0]  idx_q;
	logic [IOC_ITER_W-1:0] it_q;
	logic                  prod_vld_q;

	logic [PROD_W-1:0]     prod_q;
	logic [PROD_W-1:0]     sum_q;
	logic [PROD_W-1:0]     den_q;
	logic [PROD_W-1:0]     rem_q;
	logic [15:0]           quo_q;
	logic                  full_q;
	logic [CNT_W-1:0]      len_q;
	logic                  ovf_q;

	logic [CNT_W-1:0]      mul_a, mul_b;
	logic [PROD_W-1:0]     mul_p;
	logic [PROD_W:0]       rem2;
	logic                  div_ge;
	logic [PROD_W-1:0]     rem_nx;
	logic                  degen;
	logic [PROD_W+31:0]    sum_ext;
	logic [CNT_W+15:0]     len_ext;

	// Shared multiplier: c*(c-1) during the walk, len*(len-1) for the denominator.
	always_comb begin
		mul_a = (state_q == ST_DENOM) ? byte_count : rd_count;
		mul_b = (mul_a == '0) ? '0 : mul_a - 1'b1;
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// One restoring step of the fraction divide.
	always_comb begin
		rem2   = {rem_q, 1'b0};
		div_ge = (rem2 >= {1'b0, den_q});
		rem_nx = div_ge ? PROD_W'(rem2 - {1'b0, den_q}) : rem2[PROD_W-1:0];
	end

	// State register and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			it_q       <= '0;
			prod_vld_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			prod_vld_q <= (state_q == ST_WALK);
			if (state_q == ST_WALK) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end
			if (state_q == ST_DIV) begin
				it_q <= it_q + 1'b1;
			end else begin
				it_q <= '0;
			end
		end
	end

	// Next state and control outputs.
	always_comb begin
		state_nx        = state_q;
		bank_ctl.clear  = 1'b0;
		bank_ctl.rd_idx = idx_q;
		busy            = 1'b1;
		done            = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (launch) begin
					state_nx = ST_WALK;
				end
			end
			ST_WALK: begin
				if (idx_q == IOC_LAST_IDX) begin
					state_nx = ST_DENOM;
				end
			end
			ST_DENOM: begin
				bank_ctl.clear = 1'b1;
				state_nx       = ST_DENREG;
			end
			ST_DENREG: begin
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (it_q == IOC_ITER_W'(IOC_FRAC_BITS - 1)) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				done     = 1'b1;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q <= '0;
			end
			ST_WALK: begin
				prod_q <= mul_p;
				if (prod_vld_q) begin
					sum_q <= sum_q + prod_q;
				end
			end
			ST_DENOM: begin
				prod_q <= mul_p;
				if (prod_vld_q) begin
					sum_q <= sum_q + prod_q;
				end
				len_q <= byte_count;
				ovf_q <= overflow_seen;
			end
			ST_DENREG: begin
				den_q  <= prod_q;
				rem_q  <= sum_q;
				quo_q  <= '0;
				full_q <= (sum_q >= prod_q);
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[14:0], div_ge};
			end
			default: begin
			end
		endcase
	end

	// Result assembly with saturation of the reported sum and length.
	always_comb begin
		degen   = (len_q < CNT_W'(2));
		sum_ext = (PROD_W + 32)'(sum_q);
		len_ext = (CNT_W + 16)'(len_q);
		result.pair_sum        = (|sum_ext[PROD_W+31:32]) ? '1 : sum_ext[31:0];
		result.total_length    = (|len_ext[CNT_W+15:16]) ? '1 : len_ext[15:0];
		result.degenerate_flag = degen;
		result.overflow_flag   = ovf_q;
		if (degen) begin
			result.ioc_fixed = '0;
		end else if (full_q) begin
			result.ioc_fixed = IOC_ONE;
		end else begin
			result.ioc_fixed = {1'b0, quo_q};
		end
	end

endmodule

### rtl/core/index_of_coincidence_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// index_of_coincidence_engine: index of coincidence over a byte message
// Counts letters of a message and reports the index of coincidence.
// ----------------------------------------------------------------------------
// Usage:
//   A message enters one byte per item on in_item; an item is taken at a
//   clock edge with start high and busy low. Bytes without last_byte are
//   taken one per cycle, so a message streams in back to back.
//   The item with last_byte set starts the evaluation and raises busy. The
//   26 letter counters are walked through one shared multiplier, the
//   denominator goes through the same multiplier, and a restoring divider
//   produces the 16 fraction bits. done pulses for one cycle with the
//   result once the divide ends; busy falls in the following cycle.
//   The result must be captured in the done cycle; it is not held.
//   Counters clear during the evaluation, so the next message starts clean.
//   Reset clears all counters and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module index_of_coincidence_engine
	import ioc_pkg::*;
#(
	parameter int unsigned MAX_LENGTH = IOC_MAX_LENGTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ioc_in_t  in_item,
	output logic     done,
	output ioc_out_t result
);

	localparam int CNT_W = $clog2(64'(MAX_LENGTH) + 64'd1);

	ioc_bank_ctl_t    bank_ctl;
	logic [CNT_W-1:0] rd_count;
	logic [CNT_W-1:0] byte_count;
	logic             overflow_seen;
	logic             accept;
	logic             launch;

	// Item handshake.
	assign accept = start && !busy;
	assign launch = accept && in_item.last_byte;

	// Counter bank.
	ioc_count_bank #(
		.MAX_LENGTH (MAX_LENGTH),
		.CNT_W      (CNT_W)
	) u_bank (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_en       (accept),
		.char_byte     (in_item.char_byte),
		.bank_ctl      (bank_ctl),
		.rd_count      (rd_count),
		.byte_count    (byte_count),
		.overflow_seen (overflow_seen)
	);

	// Sequencer with the shared arithmetic.
	ioc_ratio_unit #(
		.CNT_W (CNT_W)
	) u_ratio (
		.clk           (clk),
		.arst_n        (arst_n),
		.launch        (launch),
		.rd_count      (rd_count),
		.byte_count    (byte_count),
		.overflow_seen (overflow_seen),
		.bank_ctl      (bank_ctl),
		.busy          (busy),
		.done          (done),
		.result        (result)
	);

endmodule

### rtl/core/ioc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioc_checker: port-level checks for the index of coincidence engine
// Watches the handshake and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module ioc_checker
	import ioc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input ioc_in_t  in_item,
	input logic     done,
	input ioc_out_t result
);

	// A result only appears while an evaluation is running.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done outside an evaluation");

	// A last byte taken starts an evaluation.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && in_item.last_byte) |=> busy)
		else $error("last byte did not start an evaluation");

	// The result strobe lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	// The index never exceeds one.
	a_ioc_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.ioc_fixed <= IOC_ONE))
		else $error("index above one");

	// A short message reports a zero index and a length below two.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate_flag) |->
			(result.ioc_fixed == '0) && (result.total_length < 16'd2))
		else $error("inconsistent short-message result");

endmodule

bind index_of_coincidence_engine ioc_checker u_ioc_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the index of coincidence engine
// Streams byte messages into the engine with random idle gaps, keeps its own
// letter tallies per message, and checks the pair sum, length, fixed-point
// index and both flags of every result as its done strobe fires.
// ----------------------------------------------------------------------------
module tb_top;
	import ioc_pkg::*;

	localparam int unsigned MAX_LEN       = IOC_MAX_LENGTH;
	localparam int unsigned RAND_ITEMS    = 1650;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned EVAL_CYCLES   = 60;
	localparam time         HALF_PERIOD   = 5ns;

	// One queued byte item with the idle gap that follows it.
	typedef struct {
		ioc_in_t     item;
		int unsigned gap;
		bit          drain;
	} queued_byte_t;

	logic     clk     = 1'b0;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	ioc_in_t  in_item = '0;
	logic     busy;
	logic     done;
	ioc_out_t result;

	queued_byte_t byte_queue[$];
	ioc_out_t     ioc_queue[$];

	// Message state mirrored by the predictor.
	int unsigned letter_tally[IOC_LETTERS];
	int unsigned msg_len;
	bit          dropped;

	int unsigned     idle_left;
	longint unsigned cycle_count;
	longint unsigned cycle_limit = 64'hFFFF_FFFF;
	longint unsigned budget;
	int unsigned     mismatches;
	int unsigned     bytes_taken;
	int unsigned     msgs_done;
	int unsigned     msgs_dropped;
	int unsigned     msgs_short;
	int unsigned     results_checked;

	index_of_coincidence_engine #(
		.MAX_LENGTH(MAX_LEN)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.in_item(in_item),
		.done   (done),
		.result (result)
	);

	always #HALF_PERIOD clk = ~clk;

	// Apply one accepted byte to the tallies; on the last byte, queue the result.
	function automatic void take_byte(ioc_in_t b);
		longint unsigned sum;
		longint unsigned len;
		longint unsigned den;
		longint unsigned c;
		ioc_out_t        want_res;
		bytes_taken++;
		if (msg_len >= MAX_LEN) begin
			dropped = 1'b1;
		end else begin
			msg_len++;
			if (b.char_byte >= IOC_CHAR_A && b.char_byte <= IOC_CHAR_Z)
				letter_tally[b.char_byte - IOC_CHAR_A]++;
		end
		if (!b.last_byte)
			return;

		sum = 0;
		foreach (letter_tally[i]) begin
			c = letter_tally[i];
			if (c > 1)
				sum += c * (c - 1);
		end
		len = msg_len;
		want_res.pair_sum        = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		want_res.total_length    = (len > 64'hFFFF) ? 16'hFFFF : len[15:0];
		want_res.degenerate_flag = (len < 2);
		want_res.overflow_flag   = dropped;
		if (len < 2) begin
			want_res.ioc_fixed = '0;
		end else begin
			den = len * (len - 1);
			want_res.ioc_fixed = (sum >= den) ? IOC_ONE : 17'((sum << IOC_FRAC_BITS) / den);
		end
		ioc_queue.push_back(want_res);

		msgs_done++;
		if (dropped)
			msgs_dropped++;
		if (len < 2)
			msgs_short++;
		foreach (letter_tally[i])
			letter_tally[i] = 0;
		msg_len = 0;
		dropped = 1'b0;
	endfunction

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			if (mismatches < MAX_REPORTS)
				$display("Mismatch in %s of result %0d: expected %0d, got %0d",
					name, results_checked, want, got);
			mismatches++;
		end
	endfunction

	// Gap after an item: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		else if (roll < 95)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 8);
	endfunction

	function automatic void push_byte(logic [7:0] c, bit last, int unsigned gap, bit drain);
		queued_byte_t q;
		q.item.char_byte = c;
		q.item.last_byte = last;
		q.gap            = gap;
		q.drain          = drain;
		byte_queue.push_back(q);
		budget += gap + 1 + (last ? EVAL_CYCLES : 0);
	endfunction

	function automatic void push_text(string s, bit drain);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1, pick_gap(), drain && i == 0);
	endfunction

	// Byte driver: presents queued items, honoring idle gaps and drain pauses.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			in_item   <= '0;
			idle_left <= 0;
		end else if (!start || !busy) begin
			if (start)
				take_byte(in_item);
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start     <= 1'b0;
			end else if (byte_queue.size() != 0 &&
					(!byte_queue[0].drain || (!start && !busy))) begin
				start     <= 1'b1;
				in_item   <= byte_queue[0].item;
				idle_left <= byte_queue[0].gap;
				void'(byte_queue.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result checker: each done strobe is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (ioc_queue.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("Result with none expected: %p", result);
				mismatches++;
			end else begin
				check_field("pair_sum", ioc_queue[0].pair_sum, result.pair_sum);
				check_field("total_length", ioc_queue[0].total_length, result.total_length);
				check_field("ioc_fixed", ioc_queue[0].ioc_fixed, result.ioc_fixed);
				check_field("degenerate_flag", ioc_queue[0].degenerate_flag,
					result.degenerate_flag);
				check_field("overflow_flag", ioc_queue[0].overflow_flag,
					result.overflow_flag);
				void'(ioc_queue.pop_front());
				results_checked++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("Run timed out after %0d cycles", cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned directed_n;
		int unsigned len;
		int unsigned style;
		int unsigned roll;
		logic [7:0]  base;
		int unsigned spread;
		logic [7:0]  c;

		// Directed messages: single byte, identical and distinct pairs,
		// byte extremes and the bytes just outside the letter range.
		push_text("A", 1'b1);
		push_text("AA", 1'b0);
		push_text("AB", 1'b0);
		push_text("ZZZ", 1'b0);
		push_byte(8'h00, 1'b0, pick_gap(), 1'b0);
		push_byte(8'hFF, 1'b0, pick_gap(), 1'b0);
		push_byte(IOC_CHAR_A - 1, 1'b0, pick_gap(), 1'b0);
		push_byte(IOC_CHAR_Z + 1, 1'b0, pick_gap(), 1'b0);
		push_text("az", 1'b0);
		byte_queue[byte_queue.size() - 1].item.last_byte = 1'b0;
		budget -= EVAL_CYCLES;
		push_text("Z", 1'b0);
		push_text("HELLO", 1'b0);
		directed_n = byte_queue.size();

		// Random messages: mostly letters, some narrow alphabets, some raw bytes.
		while (byte_queue.size() < directed_n + RAND_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 5)
				len = 1;
			else if (roll < 75)
				len = $urandom_range(40, 2);
			else if (roll < 95)
				len = $urandom_range(120, 41);
			else
				len = $urandom_range(300, 121);
			style  = $urandom_range(3);
			spread = $urandom_range(3);
			base   = IOC_CHAR_A + 8'($urandom_range(IOC_LETTERS - 1 - spread));
			for (int i = 0; i < len; i++) begin
				case (style)
					0: begin
						c = 8'($urandom_range(255));
					end
					1: begin
						c = IOC_CHAR_A + 8'($urandom_range(IOC_LETTERS - 1));
					end
					2: begin
						c = base + 8'($urandom_range(spread));
					end
					default: begin
						if ($urandom_range(9) < 7)
							c = IOC_CHAR_A + 8'($urandom_range(IOC_LETTERS - 1));
						else
							c = 8'($urandom_range(255));
					end
				endcase
				push_byte(c, i == len - 1, pick_gap(),
					i == 0 && (byte_queue.size() == directed_n || $urandom_range(19) == 0));
			end
		end

		// Two short closing messages; the bytes of the first are sent back to back.
		push_byte(IOC_CHAR_A, 1'b0, 0, 1'b0);
		push_byte(IOC_CHAR_A, 1'b1, pick_gap(), 1'b0);
		push_text("ABBA", 1'b0);

		cycle_limit = 4 * budget + 10000;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || start)
			@(posedge clk);
		while (ioc_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d messages: %0d single-byte, %0d past the length bound.",
			bytes_taken, msgs_done, msgs_short, msgs_dropped);
		$display("Checked %0d results, %0d field mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### index_of_coincidence_engine.f
rtl/core/ioc_pkg.sv
rtl/core/ioc_count_bank.sv
rtl/core/ioc_ratio_unit.sv
rtl/core/index_of_coincidence_engine.sv
rtl/core/ioc_checker.sv
tb/sv/tb_top.sv
